>>> rtl/state_variable_audio_filter_assert.svh
// assertion macros for the state variable audio filter
`ifndef STATE_VARIABLE_AUDIO_FILTER_ASSERT_SVH
`define STATE_VARIABLE_AUDIO_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// implication or plain property, checked outside reset
`define SVF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never hold, checked outside reset
`define SVF_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SVF_ASSERT(lbl, prop, msg)
`define SVF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/svf_pkg.sv
// shared types, codes and fixed-point helpers for the state variable filter
`default_nettype none
package svf_pkg;

	localparam int ACC_W   = 42;
	localparam int MUL_A_W = 37;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int INT_W   = 26;

	// one tenth in q0.16
	localparam logic [MUL_B_W-1:0] TENTH_Q16 = 17'd6554;

	typedef enum logic [1:0] {
		REG_FILTER_MODE = 2'd0,
		REG_CUTOFF      = 2'd1,
		REG_RESONANCE   = 2'd2
	} svf_reg_t;

	typedef enum logic [2:0] {
		MODE_OFF       = 3'd0,
		MODE_LOW       = 3'd1,
		MODE_BAND      = 3'd2,
		MODE_BAND_LOW  = 3'd3,
		MODE_HIGH      = 3'd4,
		MODE_HIGH_LOW  = 3'd5,
		MODE_HIGH_BAND = 3'd6,
		MODE_ALL       = 3'd7
	} svf_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_MUL_BF    = 3'd1,
		ST_MUL_TENTH = 3'd2,
		ST_MUL_BQ    = 3'd3,
		ST_DIFF      = 3'd4,
		ST_MUL_DF    = 3'd5,
		ST_UPDATE    = 3'd6,
		ST_RESULT    = 3'd7
	} svf_state_t;

	typedef struct packed {
		svf_state_t state;
		logic       in_ready;
		logic       mul_en;
		logic       out_load;
	} svf_ctl_t;

	// clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
		lo = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
		if (v > hi) begin
			sat32 = 32'sh7fff_ffff;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	// q16.16 to integer, truncating toward zero
	function automatic logic signed [INT_W-1:0] q16_to_int(input logic signed [ACC_W-1:0] v);
		logic signed [INT_W-1:0] q;
		q = v[ACC_W-1:16];
		if (v[ACC_W-1] && (|v[15:0])) begin
			q = q + INT_W'(1);
		end
		q16_to_int = q;
	endfunction

	// clamp to -128..127
	function automatic logic signed [7:0] sat8(input logic signed [INT_W-1:0] v);
		if (v > INT_W'(127)) begin
			sat8 = 8'sd127;
		end else if (v < -INT_W'(128)) begin
			sat8 = -8'sd128;
		end else begin
			sat8 = v[7:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/svf_mul.sv
// shared signed multiplier with registered product
`default_nettype none
module svf_mul (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [svf_pkg::MUL_A_W-1:0]  a,
	input  wire logic signed [svf_pkg::MUL_B_W-1:0]  b,
	output logic signed      [svf_pkg::PROD_W-1:0]   prod_q
);
	import svf_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end
endmodule
`default_nettype wire

>>> rtl/svf_seq.sv
// sequencer stepping one sample through the shared multiplier
`default_nettype none
module svf_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire svf_pkg::svf_mode_t  mode,
	input  wire logic                out_busy,
	output svf_pkg::svf_ctl_t        ctl
);
	import svf_pkg::*;

	svf_state_t state_q;
	svf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl.state    = state_q;
		ctl.in_ready = 1'b0;
		ctl.mul_en   = 1'b0;
		ctl.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctl.in_ready = 1'b1;
				if (in_valid) begin
					state_d = (mode == MODE_OFF) ? ST_RESULT : ST_MUL_BF;
				end
			end
			ST_MUL_BF: begin
				ctl.mul_en = 1'b1;
				state_d    = (mode == MODE_HIGH) ? ST_MUL_TENTH : ST_MUL_BQ;
			end
			ST_MUL_TENTH: begin
				ctl.mul_en = 1'b1;
				state_d    = ST_MUL_BQ;
			end
			ST_MUL_BQ: begin
				ctl.mul_en = 1'b1;
				state_d    = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = ST_MUL_DF;
			end
			ST_MUL_DF: begin
				ctl.mul_en = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/state_variable_audio_filter.sv
// state variable audio filter: one shared multiplier under a small sequencer
// flow: an accepted sample steps through b*f, tenth scaling (high-only), b*q, difference, d*f,
// update and result (straight to the result step when off); no new sample is taken until idle again
// work per sample: three products (four high-only) on one multiplier plus difference, update and result
// steps; a result waiting in the output register holds the sequencer in its result step
// reset: asynchronous active low, clears mode, coefficients and integrators; ready at once
`default_nettype none
`include "state_variable_audio_filter_assert.svh"
module state_variable_audio_filter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic signed [7:0] sample_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [7:0]      sample_out
);
	import svf_pkg::*;

	// configuration registers
	svf_mode_t   mode_q;
	logic [15:0] cutoff_q;
	logic [15:0] resonance_q;

	// filter state, q16.16
	logic signed [31:0] low_q;
	logic signed [31:0] band_q;

	// per-sample working registers
	logic signed [7:0]        x_q;
	logic signed [MUL_A_W-1:0] d_q;
	logic signed [INT_W-1:0]  t_q;

	// output register
	logic              out_valid_q;
	logic signed [7:0] sample_out_q;

	svf_ctl_t ctl;
	logic     out_busy;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [ACC_W-1:0] xq;
	logic signed [ACC_W-1:0] low_x;
	logic signed [ACC_W-1:0] band_x;
	logic signed [ACC_W-1:0] gain14;
	logic signed [ACC_W-1:0] gain16;
	logic signed [ACC_W-1:0] low_sum;
	logic signed [ACC_W-1:0] diff_xl;
	logic signed [ACC_W-1:0] diff_full;
	logic signed [ACC_W-1:0] band_sum;
	logic signed [8:0]       x_div8;
	logic signed [INT_W-1:0] r;
	logic signed [7:0]       result;
	logic                    mode_write;

	assign out_busy   = out_valid_q && !out_ready;
	assign in_ready   = ctl.in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign mode_write = cfg_we && (cfg_index == REG_FILTER_MODE);

	svf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode_q),
		.out_busy (out_busy),
		.ctl      (ctl)
	);

	// operand select for the shared multiplier
	always_comb begin
		case (ctl.state)
			ST_MUL_TENTH: begin
				// floor(b*f / 2^14) times one tenth
				mul_a = prod_q[MUL_A_W+13:14];
				mul_b = TENTH_Q16;
			end
			ST_MUL_BQ: begin
				mul_a = MUL_A_W'(band_q);
				mul_b = {1'b0, resonance_q};
			end
			ST_MUL_DF: begin
				mul_a = d_q;
				mul_b = {1'b0, cutoff_q};
			end
			default: begin
				mul_a = MUL_A_W'(band_q);
				mul_b = {1'b0, cutoff_q};
			end
		endcase
	end

	svf_mul u_mul (
		.clk    (clk),
		.en     (ctl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// arithmetic shifts give the floor rounding of the gain products
	assign xq        = {{(ACC_W-24){x_q[7]}}, x_q, 16'h0000};
	assign low_x     = ACC_W'(low_q);
	assign band_x    = ACC_W'(band_q);
	assign gain14    = ACC_W'($signed(prod_q[PROD_W-1:14]));
	assign gain16    = ACC_W'($signed(prod_q[PROD_W-1:16]));
	assign low_sum   = low_x + ((mode_q == MODE_HIGH) ? gain16 : gain14);
	assign diff_xl   = xq - low_x;
	assign diff_full = diff_xl - gain14;
	assign band_sum  = band_x + gain14;

	// x/8 truncated toward zero
	assign x_div8 = (9'(x_q) + (x_q[7] ? 9'sd7 : 9'sd0)) >>> 3;

	// output tap per mode
	always_comb begin
		case (mode_q)
			MODE_LOW, MODE_BAND_LOW: begin
				r = q16_to_int(low_x);
			end
			MODE_BAND: begin
				r = q16_to_int(band_x - ACC_W'(low_q >>> 2));
			end
			MODE_HIGH: begin
				r = q16_to_int(band_x - (ACC_W'(x_div8) <<< 16));
			end
			MODE_HIGH_LOW, MODE_ALL: begin
				r = INT_W'(x_q) - (t_q >>> 1);
			end
			MODE_HIGH_BAND: begin
				r = t_q;
			end
			default: begin
				r = '0;
			end
		endcase
	end

	assign result = sat8(r);

	// configuration registers; a new mode clears both integrators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			cutoff_q    <= '0;
			resonance_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE: mode_q      <= svf_mode_t'(cfg_data[2:0]);
				REG_CUTOFF:      cutoff_q    <= cfg_data;
				REG_RESONANCE:   resonance_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// integrators: cleared on a mode change; low updates in the b*q step, band in the update step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			band_q <= '0;
		end else if (mode_write && (cfg_data[2:0] != mode_q)) begin
			low_q  <= '0;
			band_q <= '0;
		end else if (ctl.state == ST_MUL_BQ) begin
			low_q <= sat32(low_sum);
		end else if (ctl.state == ST_UPDATE) begin
			band_q <= sat32(band_sum);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_valid && ctl.in_ready) begin
			x_q <= sample_in;
		end
		if (ctl.state == ST_DIFF) begin
			d_q <= diff_full[MUL_A_W-1:0];
			t_q <= q16_to_int(diff_xl);
		end
	end

	// output register, holds a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			sample_out_q <= result;
		end
	end

	`SVF_ASSERT(a_accept_starts, (in_valid && in_ready && mode_q != MODE_OFF) |=> (ctl.state == ST_MUL_BF), "accepted sample did not start the product chain")
	`SVF_ASSERT(a_tenth_high_only, (ctl.state == ST_MUL_TENTH) |-> (mode_q == MODE_HIGH), "tenth scaling outside high-only mode")
	`SVF_ASSERT_NEVER(a_no_overwrite, ctl.out_load && out_valid_q && !out_ready, "result overwrote a pending output")
	`SVF_ASSERT(a_mode_clears, (mode_write && cfg_data[2:0] != mode_q) |=> (low_q == 32'sd0 && band_q == 32'sd0), "mode change did not clear the integrators")
endmodule
`default_nettype wire
